/* src/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and constants of the rtp l16 packetizer
// payload structs, job descriptor, register indexes and byte positions
// ----------------------------------------------------------------------------
package rtp_pkg;

  // default bound on samples per packet
  localparam int MaxSamplesDefault = 1024;
  // default depth of the job queue between front and back end
  localparam int JobDepthDefault   = 4;

  // configuration register indexes
  localparam logic [2:0] RegSamplesPerPacket = 3'd0;
  localparam logic [2:0] RegInterleavedMode  = 3'd1;
  localparam logic [2:0] RegChannelId        = 3'd2;
  localparam logic [2:0] RegPayloadType      = 3'd3;
  localparam logic [2:0] RegSyncSource       = 3'd4;
  localparam logic [2:0] RegStartSequence    = 3'd5;
  localparam logic [2:0] RegStartTimestamp   = 3'd6;

  // fixed header bytes
  localparam logic [7:0] ByteDollar  = 8'h24;
  localparam logic [7:0] ByteVersion = 8'h80;

  // positions in the byte sequence of one job
  localparam logic [4:0] IdxDollar   = 5'd0;
  localparam logic [4:0] IdxChannel  = 5'd1;
  localparam logic [4:0] IdxLenHi    = 5'd2;
  localparam logic [4:0] IdxLenLo    = 5'd3;
  localparam logic [4:0] IdxVersion  = 5'd4;
  localparam logic [4:0] IdxPtype    = 5'd5;
  localparam logic [4:0] IdxSeqHi    = 5'd6;
  localparam logic [4:0] IdxSeqLo    = 5'd7;
  localparam logic [4:0] IdxTs3      = 5'd8;
  localparam logic [4:0] IdxTs2      = 5'd9;
  localparam logic [4:0] IdxTs1      = 5'd10;
  localparam logic [4:0] IdxTs0      = 5'd11;
  localparam logic [4:0] IdxSsrc3    = 5'd12;
  localparam logic [4:0] IdxSsrc2    = 5'd13;
  localparam logic [4:0] IdxSsrc1    = 5'd14;
  localparam logic [4:0] IdxSsrc0    = 5'd15;
  localparam logic [4:0] IdxSampleHi = 5'd16;
  localparam logic [4:0] IdxSampleLo = 5'd17;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               backlog_full;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_last;
  } out_item_t;

  // one sample's work for the back end
  typedef struct packed {
    logic [15:0] sample;
    logic        hdr;
    logic        ilv;
    logic        closes;
    logic [7:0]  channel;
    logic [6:0]  ptype;
    logic [15:0] wire_len;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] ssrc;
  } job_t;

endpackage

/* src/rtp_queue.sv */
// ----------------------------------------------------------------------------
// rtp_queue: job queue
// small register fifo between the front and back end
// ----------------------------------------------------------------------------
module rtp_queue
  import rtp_pkg::*;
#(
  parameter int DEPTH = JobDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job queue read while empty");
`endif

endmodule

/* src/rtp_front.sv */
// ----------------------------------------------------------------------------
// rtp_front: sample front end
// configuration registers, sequence and timestamp counters, packet position
// ----------------------------------------------------------------------------
module rtp_front
  import rtp_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        accept,
  input  in_item_t    in_item,
  output logic        q_push,
  output job_t        q_wdata
);

  localparam int PosW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [10:0]     samples_per_packet;
  logic            interleaved_mode;
  logic [7:0]      channel_id;
  logic [6:0]      payload_type;
  logic [31:0]     sync_source;
  logic [15:0]     seq_counter;
  logic [31:0]     time_counter;
  logic [PosW-1:0] pos;
  logic            drop_latch;

  logic [10:0] n_eff;
  logic [15:0] pos_inc;
  logic        first;
  logic        closes;
  logic        drop_now;
  logic [15:0] seq_load;

  always_comb begin
    if (samples_per_packet == '0) begin
      n_eff = 11'd1;
    end else if (32'(samples_per_packet) > MAX_SAMPLES) begin
      n_eff = 11'(MAX_SAMPLES);
    end else begin
      n_eff = samples_per_packet;
    end
  end

  assign pos_inc  = 16'(pos) + 16'd1;
  assign first    = (pos == '0);
  assign closes   = (pos_inc >= 16'(n_eff));
  assign drop_now = first ? (interleaved_mode && in_item.backlog_full) : drop_latch;
  assign seq_load = (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];

  assign q_push            = accept && !drop_now;
  assign q_wdata.sample    = in_item.sample;
  assign q_wdata.hdr       = first;
  assign q_wdata.ilv       = interleaved_mode;
  assign q_wdata.closes    = closes;
  assign q_wdata.channel   = channel_id;
  assign q_wdata.ptype     = payload_type;
  assign q_wdata.wire_len  = 16'd12 + {4'd0, n_eff, 1'b0};
  assign q_wdata.seq       = seq_counter;
  assign q_wdata.stamp     = time_counter;
  assign q_wdata.ssrc      = sync_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_packet <= 11'd320;
      interleaved_mode   <= 1'b0;
      channel_id         <= 8'd0;
      payload_type       <= 7'd96;
      sync_source        <= 32'd1;
      seq_counter        <= 16'd1;
      time_counter       <= 32'd0;
      pos                <= '0;
      drop_latch         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegSamplesPerPacket: samples_per_packet <= cfg_data[10:0];
        RegInterleavedMode:  interleaved_mode   <= cfg_data[0];
        RegChannelId:        channel_id         <= cfg_data[7:0];
        RegPayloadType:      payload_type       <= cfg_data[6:0];
        RegSyncSource:       sync_source        <= cfg_data;
        RegStartSequence:    seq_counter        <= seq_load;
        RegStartTimestamp:   time_counter       <= cfg_data;
        default:             ;
      endcase
    end else if (accept) begin
      drop_latch <= drop_now;
      if (closes) begin
        pos          <= '0;
        seq_counter  <= seq_counter + 16'd1;
        time_counter <= time_counter + {21'd0, n_eff};
      end else begin
        pos <= pos_inc[PosW-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_seq_load_nonzero: assert property (@(posedge clk) disable iff (rst)
      (cfg_write && cfg_index == RegStartSequence) |=> (seq_counter != 16'd0))
    else $error("sequence loaded as zero");
  a_drop_only_ilv: assert property (@(posedge clk) disable iff (rst)
      (accept && first && !interleaved_mode) |-> q_push)
    else $error("packet dropped in plain mode");
`endif

endmodule

/* src/rtp_back.sv */
// ----------------------------------------------------------------------------
// rtp_back: byte back end
// walks each job's header and sample bytes into the output register
// ----------------------------------------------------------------------------
module rtp_back
  import rtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic       out_valid;
  logic       mid;
  logic [4:0] idx;
  logic [4:0] cur_idx;
  logic       load;
  logic [7:0] byte_sel;

  always_comb begin
    if (mid) begin
      cur_idx = idx;
    end else if (head.hdr) begin
      cur_idx = head.ilv ? IdxDollar : IdxVersion;
    end else begin
      cur_idx = IdxSampleHi;
    end
  end

  always_comb begin
    case (cur_idx)
      IdxDollar:   byte_sel = ByteDollar;
      IdxChannel:  byte_sel = head.channel;
      IdxLenHi:    byte_sel = head.wire_len[15:8];
      IdxLenLo:    byte_sel = head.wire_len[7:0];
      IdxVersion:  byte_sel = ByteVersion;
      IdxPtype:    byte_sel = {1'b0, head.ptype};
      IdxSeqHi:    byte_sel = head.seq[15:8];
      IdxSeqLo:    byte_sel = head.seq[7:0];
      IdxTs3:      byte_sel = head.stamp[31:24];
      IdxTs2:      byte_sel = head.stamp[23:16];
      IdxTs1:      byte_sel = head.stamp[15:8];
      IdxTs0:      byte_sel = head.stamp[7:0];
      IdxSsrc3:    byte_sel = head.ssrc[31:24];
      IdxSsrc2:    byte_sel = head.ssrc[23:16];
      IdxSsrc1:    byte_sel = head.ssrc[15:8];
      IdxSsrc0:    byte_sel = head.ssrc[7:0];
      IdxSampleHi: byte_sel = head.sample[15:8];
      IdxSampleLo: byte_sel = head.sample[7:0];
      default:     byte_sel = 8'd0;
    endcase
  end

  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && (cur_idx == IdxSampleLo);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte    <= byte_sel;
      out_item.packet_last <= (cur_idx == IdxSampleLo) && head.closes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mid       <= 1'b0;
      idx       <= IdxDollar;
    end else if (load) begin
      out_valid <= 1'b1;
      mid       <= (cur_idx != IdxSampleLo);
      idx       <= cur_idx + 5'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_mid_has_job: assert property (@(posedge clk) disable iff (rst) mid |-> !q_empty)
    else $error("job left the queue before its last byte");
  a_idx_range: assert property (@(posedge clk) disable iff (rst) mid |-> (idx <= IdxSampleLo))
    else $error("byte position past the sample");
`endif

endmodule

/* src/rtp_l16_packetizer.sv */
// ----------------------------------------------------------------------------
// rtp_l16_packetizer: rtp l16 audio packetizer
// turns 16-bit pcm samples into the byte stream of rtp packets
// ----------------------------------------------------------------------------
// one sample request in gives its two big-endian payload bytes out, preceded
// on a packet's first sample by the 12-byte rtp header and, in interleaved
// mode, the 4-byte '$' frame header. the output runs one byte per cycle while
// jobs are queued and the reader pops each byte, so a packet's first sample
// gives 14 bytes (plain) or 18 (interleaved) and the output byte port sets the
// pace. the input takes one sample a cycle until the job queue (QUEUE_DEPTH
// entries) between the front and back end fills, so header bursts are absorbed.
// packets dropped for backlog in interleaved mode produce no bytes but still
// advance sequence and timestamp. write configuration only while idle.
module rtp_l16_packetizer
  import rtp_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDefault,
  parameter int QUEUE_DEPTH = JobDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // sample requests
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  // byte requests
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item
);

  logic accept;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_wdata;
  job_t q_head;

  // a request is taken whenever the job queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front end: counters, packet position and drop decision
  rtp_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_item   (in_item),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // decouples sample intake from byte output
  rtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // back end: byte serializer with registered output
  rtp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  a_out_needs_job: assert property (@(posedge clk) disable iff (rst)
      (q_empty && empty) |=> empty)
    else $error("byte appeared without a queued job");
`endif

endmodule
